### rtl/core/sma_pkg.sv
// sma_pkg: shared types and constants for the moving average block
// sequencer states, divider control/status structs and fixed field widths
// no dependencies
package sma_pkg;

    localparam int FIELD_W      = 32;
    localparam int LEN_W        = 9;
    localparam int WINDOW_RESET = 20;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_SUB,
        S_DIV,
        S_DONE
    } seq_state_t;

    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

### rtl/core/simple_moving_average_top.sv
// simple_moving_average_top: boxcar average over the last window_length prices
// depends on sma_pkg, sma_history and sma_divider
//
//   channel   direction  signals
//   cfg       in         cfg_valid / cfg_ready, window_length
//   in        in         in_valid / in_ready, close_price, time_tag
//   out       out        out_valid / out_ready, average_price, result_time_tag
//
// an item passes S_ADD and S_SUB, then waits in S_DIV on the bit-serial divider and in S_DONE for the output
// items that only fill the window pass S_ADD and S_SUB and give no result
// in_ready is low while an item is in work, also while its result waits for the output
// reset restores window_length 20 and empties the window; a cfg write loads the new length and also empties it
module simple_moving_average_top
    import sma_pkg::*;
#(
    parameter int MAX_WINDOW = 256,
    parameter int PRICE_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [LEN_W-1:0]   window_length,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [FIELD_W-1:0] close_price,
    input  logic [FIELD_W-1:0] time_tag,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [FIELD_W-1:0] average_price,
    output logic [FIELD_W-1:0] result_time_tag
);

    localparam int          AW      = $clog2(MAX_WINDOW);
    localparam int          SUM_W   = PRICE_BITS + $clog2(MAX_WINDOW + 1);
    localparam logic [31:0] MAX_W32 = 32'(MAX_WINDOW);

    seq_state_t state_reg, state_next;

    logic [LEN_W-1:0]      wl_reg;
    logic [LEN_W-1:0]      len_eff;
    logic [SUM_W-1:0]      sum_reg;
    logic [LEN_W-1:0]      filled_reg;
    logic [AW-1:0]         slot_reg;
    logic [AW-1:0]         slot_next;
    logic [31:0]           slot_inc;
    logic                  full_reg;
    logic                  emit_reg;
    logic [PRICE_BITS-1:0] price_reg;
    logic [FIELD_W-1:0]    tag_reg;
    logic [PRICE_BITS+FIELD_W-1:0] price_wide;
    logic [SUM_W+FIELD_W-1:0]      quot_wide;
    logic                  out_valid_reg;
    logic [FIELD_W-1:0]    out_avg_reg;
    logic [FIELD_W-1:0]    out_tag_reg;
    logic                  in_take;
    logic                  cfg_take;
    logic                  out_load;
    logic                  mem_wr_en;
    logic [PRICE_BITS-1:0] old_price;
    logic [SUM_W-1:0]      quotient;
    div_ctrl_t             div_ctrl;
    div_stat_t             div_stat;

    // zero means one, above the memory depth means the depth
    always_comb
    begin
        len_eff = wl_reg;
        if (wl_reg == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (32'(wl_reg) > MAX_W32)
        begin
            len_eff = LEN_W'(MAX_WINDOW);
        end
    end

    assign slot_inc  = 32'(slot_reg) + 32'd1;
    assign slot_next = (slot_inc >= 32'(len_eff)) ? '0 : AW'(slot_inc);

    assign price_wide = {{PRICE_BITS{1'b0}}, close_price};
    assign quot_wide  = {{FIELD_W{1'b0}}, quotient};

    assign in_take  = in_valid && in_ready;
    assign cfg_take = cfg_valid && cfg_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                state_next = S_SUB;
            end
            S_SUB:
            begin
                state_next = emit_reg ? S_DIV : S_IDLE;
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cfg_ready      = 1'b0;
        in_ready       = 1'b0;
        mem_wr_en      = 1'b0;
        div_ctrl.start = 1'b0;
        out_load       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                cfg_ready = 1'b1;
                in_ready  = !cfg_valid;
            end
            S_SUB:
            begin
                mem_wr_en      = 1'b1;
                div_ctrl.start = emit_reg;
            end
            S_DONE:
            begin
                out_load = !out_valid_reg || out_ready;
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wl_reg        <= LEN_W'(WINDOW_RESET);
            sum_reg       <= '0;
            filled_reg    <= '0;
            slot_reg      <= '0;
            full_reg      <= 1'b0;
            emit_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_take)
            begin
                wl_reg     <= window_length;
                sum_reg    <= '0;
                filled_reg <= '0;
                slot_reg   <= '0;
            end
            if (in_take)
            begin
                full_reg <= (filled_reg >= len_eff);
                emit_reg <= (filled_reg >= len_eff)
                            || ((filled_reg + LEN_W'(1)) == len_eff);
            end
            // newest price in, oldest out once the window is full
            if (state_reg == S_ADD)
            begin
                sum_reg <= sum_reg + SUM_W'(price_reg)
                           - (full_reg ? SUM_W'(old_price) : SUM_W'(0));
            end
            if (state_reg == S_SUB)
            begin
                if (!full_reg)
                begin
                    filled_reg <= filled_reg + LEN_W'(1);
                end
                slot_reg <= slot_next;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            price_reg <= price_wide[PRICE_BITS-1:0];
            tag_reg   <= time_tag;
        end
        if (out_load)
        begin
            out_avg_reg <= quot_wide[FIELD_W-1:0];
            out_tag_reg <= tag_reg;
        end
    end

    sma_history #(
        .DEPTH  (MAX_WINDOW),
        .DATA_W (PRICE_BITS)
    ) u_history (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (slot_reg),
        .wr_data (price_reg),
        .rd_addr (slot_reg),
        .rd_data (old_price)
    );

    sma_divider #(
        .NUM_W (SUM_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .dividend (sum_reg),
        .divisor  (len_eff),
        .stat     (div_stat),
        .quotient (quotient)
    );

    assign out_valid       = out_valid_reg;
    assign average_price   = out_avg_reg;
    assign result_time_tag = out_tag_reg;

endmodule

### rtl/core/sma_history.sv
// sma_history: circular price delay line, one write and one registered read port
// depends on nothing but its parameters
module sma_history #(
    parameter int DEPTH  = 256,
    parameter int DATA_W = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/sma_divider.sv
// sma_divider: restoring bit-serial divider, one quotient bit per cycle
// depends on sma_pkg for the divisor width and control structs
module sma_divider
    import sma_pkg::*;
#(
    parameter int NUM_W = 40
) (
    input  logic             clk,
    input  logic             rst_n,
    input  div_ctrl_t        ctrl,
    input  logic [NUM_W-1:0] dividend,
    input  logic [LEN_W-1:0] divisor,
    output div_stat_t        stat,
    output logic [NUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] work_reg, work_next;
    logic [LEN_W-1:0] rem_reg, rem_next;
    logic [LEN_W-1:0] dsr_reg, dsr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [LEN_W:0]   rem_shift;
    logic [LEN_W:0]   rem_diff;
    logic             fits;

    // one subtract/compare per cycle
    assign rem_shift = {rem_reg, work_reg[NUM_W-1]};
    assign rem_diff  = rem_shift - {1'b0, dsr_reg};
    assign fits      = (rem_shift >= {1'b0, dsr_reg});

    always_comb
    begin
        work_next  = work_reg;
        rem_next   = rem_reg;
        dsr_next   = dsr_reg;
        count_next = count_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (ctrl.start)
        begin
            work_next  = dividend;
            rem_next   = '0;
            dsr_next   = divisor;
            count_next = CNT_W'(NUM_W);
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            work_next  = {work_reg[NUM_W-2:0], fits};
            rem_next   = fits ? rem_diff[LEN_W-1:0] : rem_shift[LEN_W-1:0];
            count_next = count_reg - CNT_W'(1);
            if (count_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = work_reg;

endmodule
